@@ design/rasr_pkg.sv @@
package rasr_pkg;

	localparam int REG_INDEX_BITS = 3;
	localparam int REG_DATA_BITS = 13;

	localparam logic [REG_INDEX_BITS-1:0] REG_SPRITE_WIDTH = 3'd0;
	localparam logic [REG_INDEX_BITS-1:0] REG_ORIGIN_X = 3'd1;
	localparam logic [REG_INDEX_BITS-1:0] REG_ORIGIN_Y = 3'd2;
	localparam logic [REG_INDEX_BITS-1:0] REG_DEST_WIDTH = 3'd3;
	localparam logic [REG_INDEX_BITS-1:0] REG_DEST_HEIGHT = 3'd4;
	localparam logic [REG_INDEX_BITS-1:0] REG_PALETTE_MODE = 3'd5;
	localparam logic [REG_INDEX_BITS-1:0] REG_PALETTE_SELECT = 3'd6;

	localparam logic [1:0] KIND_RUN = 2'b00;
	localparam logic [1:0] KIND_LINE_SKIP = 2'b01;

	localparam logic [7:0] WHITE = 8'hFF;

	typedef struct packed {
		logic [11:0] sprite_width;
		logic signed [12:0] origin_x;
		logic signed [12:0] origin_y;
		logic [12:0] dest_width;
		logic [12:0] dest_height;
		logic palette_mode;
		logic [3:0] palette_select;
	} rasr_cfg_t;

	typedef struct packed {
		logic [3:0] coverage;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic last;
	} rasr_pix_t;

	localparam logic [7:0] PAL_RED [256] = '{
		8'h40,8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8C,8'h98,8'hA5,8'hB3,8'hC3,8'hD4,8'hE7,
		8'h40,8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8C,8'h98,8'hA5,8'hB3,8'hC3,8'hD4,8'hE7,
		8'h15,8'h17,8'h19,8'h1C,8'h1F,8'h22,8'h25,8'h29,8'h2D,8'h31,8'h36,8'h3B,8'h41,8'h47,8'h4E,8'h55,
		8'h15,8'h17,8'h19,8'h1C,8'h1F,8'h22,8'h25,8'h29,8'h2D,8'h31,8'h36,8'h3B,8'h41,8'h47,8'h4E,8'h55,
		8'h35,8'h3A,8'h3F,8'h45,8'h4B,8'h52,8'h5A,8'h62,8'h6B,8'h75,8'h80,8'h8B,8'h97,8'hA4,8'hB2,8'hC2,
		8'h35,8'h3A,8'h3F,8'h45,8'h4B,8'h52,8'h5A,8'h62,8'h6B,8'h75,8'h80,8'h8B,8'h97,8'hA4,8'hB2,8'hC2,
		8'h11,8'h13,8'h15,8'h17,8'h1A,8'h1D,8'h20,8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,
		8'h11,8'h13,8'h15,8'h17,8'h1A,8'h1D,8'h20,8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,
		8'h20,8'h23,8'h26,8'h2A,8'h2E,8'h32,8'h37,8'h3C,8'h42,8'h48,8'h4F,8'h56,8'h5E,8'h67,8'h70,8'h7A,
		8'h3D,8'h43,8'h49,8'h50,8'h57,8'h5F,8'h68,8'h71,8'h7B,8'h86,8'h92,8'h9F,8'hAD,8'hBC,8'hCC,8'hDE,
		8'h40,8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8C,8'h98,8'hA5,8'hB3,8'hC3,8'hD4,8'hE7,
		8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,8'h51,8'h58,8'h60,8'h69,8'h72,8'h7C,8'h87,
		8'h35,8'h3A,8'h3F,8'h45,8'h4B,8'h52,8'h5A,8'h62,8'h6B,8'h75,8'h80,8'h8B,8'h97,8'hA4,8'hB2,8'hC2,
		8'h30,8'h35,8'h3A,8'h40,8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8D,8'h99,8'hA6,8'hB5,
		8'h11,8'h13,8'h15,8'h17,8'h1A,8'h1D,8'h20,8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,
		8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8D,8'h9A,8'hA8,8'hB7,8'hC7,8'hD8,8'hEB,8'hFF
	};

	localparam logic [7:0] PAL_GREEN [256] = '{
		8'h15,8'h17,8'h19,8'h1C,8'h1F,8'h22,8'h25,8'h29,8'h2D,8'h31,8'h36,8'h3B,8'h41,8'h47,8'h4E,8'h55,
		8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,8'h51,8'h58,8'h60,8'h69,8'h72,8'h7C,8'h87,8'h93,
		8'h40,8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8C,8'h98,8'hA5,8'hB3,8'hC3,8'hD4,8'hE7,
		8'h30,8'h35,8'h3A,8'h40,8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8D,8'h9A,8'hA8,8'hB7,
		8'h11,8'h13,8'h15,8'h17,8'h1A,8'h1D,8'h20,8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,
		8'h28,8'h2C,8'h30,8'h35,8'h3A,8'h40,8'h46,8'h4D,8'h54,8'h5C,8'h64,8'h6D,8'h77,8'h82,8'h8E,8'h9B,
		8'h35,8'h3A,8'h3F,8'h45,8'h4B,8'h52,8'h5A,8'h62,8'h6B,8'h75,8'h80,8'h8B,8'h97,8'hA4,8'hB2,8'hC2,
		8'h20,8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,8'h51,8'h58,8'h60,8'h69,8'h72,8'h7C,
		8'h15,8'h17,8'h19,8'h1C,8'h1F,8'h22,8'h25,8'h29,8'h2D,8'h31,8'h36,8'h3B,8'h41,8'h47,8'h4E,8'h55,
		8'h15,8'h17,8'h19,8'h1C,8'h1F,8'h22,8'h25,8'h29,8'h2D,8'h31,8'h36,8'h3B,8'h41,8'h47,8'h4E,8'h55,
		8'h3A,8'h3F,8'h45,8'h4B,8'h52,8'h5A,8'h62,8'h6B,8'h75,8'h7F,8'h8A,8'h96,8'hA3,8'hB1,8'hC1,8'hD2,
		8'h11,8'h13,8'h15,8'h17,8'h1A,8'h1D,8'h20,8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,
		8'h11,8'h13,8'h15,8'h17,8'h1A,8'h1D,8'h20,8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,
		8'h35,8'h3A,8'h3F,8'h45,8'h4B,8'h52,8'h5A,8'h62,8'h6B,8'h75,8'h80,8'h8B,8'h97,8'hA4,8'hB2,8'hC2,
		8'h35,8'h3A,8'h3F,8'h45,8'h4B,8'h52,8'h5A,8'h62,8'h6B,8'h75,8'h80,8'h8B,8'h97,8'hA4,8'hB2,8'hC2,
		8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8D,8'h9A,8'hA8,8'hB7,8'hC7,8'hD8,8'hEB,8'hFF
	};

	localparam logic [7:0] PAL_BLUE [256] = '{
		8'h20,8'h23,8'h27,8'h2B,8'h2F,8'h33,8'h38,8'h3D,8'h43,8'h49,8'h50,8'h57,8'h5F,8'h68,8'h71,8'h7B,
		8'h15,8'h17,8'h19,8'h1C,8'h1F,8'h22,8'h25,8'h29,8'h2D,8'h31,8'h36,8'h3B,8'h41,8'h47,8'h4E,8'h55,
		8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,8'h51,8'h58,8'h60,8'h69,8'h72,8'h7C,8'h87,
		8'h40,8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8C,8'h98,8'hA5,8'hB3,8'hC3,8'hD4,8'hE7,
		8'h12,8'h14,8'h16,8'h18,8'h1B,8'h1E,8'h21,8'h24,8'h28,8'h2C,8'h30,8'h35,8'h3A,8'h3F,8'h45,8'h4B,
		8'h11,8'h13,8'h15,8'h17,8'h1A,8'h1D,8'h20,8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,
		8'h26,8'h2A,8'h2E,8'h32,8'h37,8'h3C,8'h42,8'h48,8'h4F,8'h56,8'h5E,8'h67,8'h70,8'h7A,8'h85,8'h91,
		8'h35,8'h3A,8'h3F,8'h45,8'h4B,8'h52,8'h5A,8'h62,8'h6B,8'h75,8'h80,8'h8B,8'h97,8'hA4,8'hB2,8'hC2,
		8'h40,8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8C,8'h98,8'hA5,8'hB3,8'hC3,8'hD4,8'hE7,
		8'h40,8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8C,8'h98,8'hA5,8'hB3,8'hC3,8'hD4,8'hE7,
		8'h15,8'h17,8'h19,8'h1C,8'h1F,8'h22,8'h25,8'h29,8'h2D,8'h31,8'h36,8'h3B,8'h41,8'h47,8'h4E,8'h55,
		8'h35,8'h3A,8'h3F,8'h45,8'h4B,8'h52,8'h5A,8'h62,8'h6B,8'h75,8'h80,8'h8B,8'h97,8'hA4,8'hB2,8'hC2,
		8'h2E,8'h32,8'h37,8'h3C,8'h42,8'h48,8'h4F,8'h56,8'h5E,8'h66,8'h6F,8'h79,8'h84,8'h90,8'h9D,8'hAB,
		8'h11,8'h13,8'h15,8'h17,8'h1A,8'h1D,8'h20,8'h23,8'h27,8'h2B,8'h2F,8'h34,8'h39,8'h3E,8'h44,8'h4A,
		8'h15,8'h17,8'h1A,8'h1D,8'h20,8'h23,8'h26,8'h2A,8'h2E,8'h32,8'h37,8'h3C,8'h42,8'h48,8'h4F,8'h56,
		8'h46,8'h4C,8'h53,8'h5B,8'h63,8'h6C,8'h76,8'h81,8'h8D,8'h9A,8'hA8,8'hB7,8'hC7,8'hD8,8'hEB,8'hFF
	};

	function automatic rasr_pix_t pixel_colour(input logic mode, input logic [3:0] row,
			input logic [3:0] nib);
		rasr_pix_t p;
		logic [7:0] idx;
		idx = {row, nib};
		p.coverage = nib;
		p.red = mode ? PAL_RED[idx] : WHITE;
		p.green = mode ? PAL_GREEN[idx] : WHITE;
		p.blue = mode ? PAL_BLUE[idx] : WHITE;
		p.last = 1'b0;
		return p;
	endfunction

endpackage

@@ design/rasr_cfg_regs.sv @@
module rasr_cfg_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [rasr_pkg::REG_INDEX_BITS-1:0]   cfg_index,
	input  logic [rasr_pkg::REG_DATA_BITS-1:0]    cfg_data,
	output rasr_pkg::rasr_cfg_t                   cfg
);
	import rasr_pkg::*;

	rasr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sprite_width <= 12'd1;
			cfg_q.origin_x <= 13'sd0;
			cfg_q.origin_y <= 13'sd0;
			cfg_q.dest_width <= 13'd4096;
			cfg_q.dest_height <= 13'd4096;
			cfg_q.palette_mode <= 1'b0;
			cfg_q.palette_select <= 4'd0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SPRITE_WIDTH: cfg_q.sprite_width <= cfg_data[11:0];
				REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				REG_DEST_WIDTH: cfg_q.dest_width <= cfg_data;
				REG_DEST_HEIGHT: cfg_q.dest_height <= cfg_data;
				REG_PALETTE_MODE: cfg_q.palette_mode <= cfg_data[0];
				REG_PALETTE_SELECT: cfg_q.palette_select <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/rasr_decode.sv @@
module rasr_decode #(
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rasr_pkg::rasr_cfg_t     cfg,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              sprite_byte,
	input  logic                    first_of_frame,
	input  logic                    queue_free,
	output logic                    load,
	output logic                    pix0_valid,
	output logic [COORD_BITS-1:0]   pix0_x,
	output logic [COORD_BITS-1:0]   pix0_y,
	output rasr_pkg::rasr_pix_t     pix0,
	output logic                    pix1_valid,
	output logic [COORD_BITS-1:0]   pix1_x,
	output logic [COORD_BITS-1:0]   pix1_y,
	output rasr_pkg::rasr_pix_t     pix1
);
	import rasr_pkg::*;

	typedef struct packed {
		logic [15:0] cc;
		logic [16:0] cx;
		logic [16:0] cy;
	} cursor_t;

	localparam logic [16:0] CAP = 17'(2 ** COORD_BITS);

	function automatic cursor_t wrap_col(input cursor_t c, input logic [11:0] sw);
		cursor_t r;
		r = c;
		if (c.cc >= {4'd0, sw}) begin
			r.cc = c.cc - {4'd0, sw};
			r.cy = c.cy + 17'd1;
			r.cx = c.cx - {5'd0, sw};
		end
		return r;
	endfunction

	function automatic cursor_t step_col(input cursor_t c);
		cursor_t r;
		r = c;
		r.cc = c.cc + 16'd1;
		r.cx = c.cx + 17'd1;
		return r;
	endfunction

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic [5:0]  run_left_q;
	cursor_t     cur_q;

	logic        accept;
	cursor_t     c0, c_ctrl, a, b, c, d, c_next;
	logic [5:0]  run0, run_next;
	logic [5:0]  len;
	logic [3:0]  hi;
	logic        emit1;
	logic [16:0] lim_x, lim_y;
	logic        vis0, vis1;

	assign load = valid_s1 && queue_free;
	assign in_stall = valid_s1 && !queue_free;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= sprite_byte;
			first_s1 <= first_of_frame;
		end
	end

	always_comb begin
		lim_x = ({4'd0, cfg.dest_width} > CAP) ? CAP : {4'd0, cfg.dest_width};
		lim_y = ({4'd0, cfg.dest_height} > CAP) ? CAP : {4'd0, cfg.dest_height};
		len = byte_s1[5:0];
		hi = byte_s1[7:4];

		c0 = cur_q;
		run0 = run_left_q;
		if (first_s1) begin
			c0.cc = 16'd0;
			c0.cx = {{4{cfg.origin_x[12]}}, cfg.origin_x};
			c0.cy = {{4{cfg.origin_y[12]}}, cfg.origin_y};
			run0 = 6'd0;
		end

		c_ctrl = c0;
		run_next = run0;
		if (byte_s1[7:6] == KIND_LINE_SKIP) begin
			c_ctrl.cy = c0.cy + {11'd0, len};
		end else if (byte_s1[7:6] == KIND_RUN) begin
			run_next = len;
		end else begin
			c_ctrl.cc = c0.cc + {10'd0, len};
			c_ctrl.cx = c0.cx + {11'd0, len};
			c_ctrl = wrap_col(c_ctrl, cfg.sprite_width);
		end

		a = wrap_col(c0, cfg.sprite_width);
		b = step_col(a);
		c = wrap_col(b, cfg.sprite_width);
		d = step_col(c);
		emit1 = !((run0 == 6'd1) && (hi == 4'd0));
		vis0 = !a.cx[16] && !a.cy[16] && (a.cx < lim_x) && (a.cy < lim_y);
		vis1 = !c.cx[16] && !c.cy[16] && (c.cx < lim_x) && (c.cy < lim_y);

		if (run0 == 6'd0) begin
			c_next = c_ctrl;
			pix0_valid = 1'b0;
			pix1_valid = 1'b0;
		end else begin
			c_next = emit1 ? d : b;
			run_next = run0 - 6'd1;
			pix0_valid = vis0;
			pix1_valid = emit1 && vis1;
		end

		pix0_x = a.cx[COORD_BITS-1:0];
		pix0_y = a.cy[COORD_BITS-1:0];
		pix1_x = c.cx[COORD_BITS-1:0];
		pix1_y = c.cy[COORD_BITS-1:0];
		pix0 = pixel_colour(cfg.palette_mode, cfg.palette_select, byte_s1[3:0]);
		pix0.last = !pix1_valid;
		pix1 = pixel_colour(cfg.palette_mode, cfg.palette_select, hi);
		pix1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_left_q <= 6'd0;
			cur_q <= '0;
		end else if (load) begin
			run_left_q <= run_next;
			cur_q <= c_next;
		end
	end

endmodule

@@ design/rasr_out_queue.sv @@
module rasr_out_queue #(
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic                    pix0_valid,
	input  logic [COORD_BITS-1:0]   pix0_x,
	input  logic [COORD_BITS-1:0]   pix0_y,
	input  rasr_pkg::rasr_pix_t     pix0,
	input  logic                    pix1_valid,
	input  logic [COORD_BITS-1:0]   pix1_x,
	input  logic [COORD_BITS-1:0]   pix1_y,
	input  rasr_pkg::rasr_pix_t     pix1,
	output logic                    queue_free,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [COORD_BITS-1:0]   pixel_x,
	output logic [COORD_BITS-1:0]   pixel_y,
	output logic [3:0]              coverage,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue,
	output logic                    last
);
	import rasr_pkg::*;

	logic                  v0_q, v1_q;
	logic [COORD_BITS-1:0] x0_q, y0_q, x1_q, y1_q;
	rasr_pix_t             p0_q, p1_q;
	rasr_pix_t             head;
	logic                  xfer;

	assign out_valid = v0_q || v1_q;
	assign xfer = out_valid && !out_stall;
	assign queue_free = !out_valid || (xfer && !(v0_q && v1_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (load) begin
			v0_q <= pix0_valid;
			v1_q <= pix1_valid;
		end else if (xfer) begin
			if (v0_q) begin
				v0_q <= 1'b0;
			end else begin
				v1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x0_q <= pix0_x;
			y0_q <= pix0_y;
			p0_q <= pix0;
			x1_q <= pix1_x;
			y1_q <= pix1_y;
			p1_q <= pix1;
		end
	end

	assign head = v0_q ? p0_q : p1_q;
	assign pixel_x = v0_q ? x0_q : x1_q;
	assign pixel_y = v0_q ? y0_q : y1_q;
	assign coverage = head.coverage;
	assign red = head.red;
	assign green = head.green;
	assign blue = head.blue;
	assign last = head.last;

endmodule

@@ design/rle_alpha_sprite_rasterizer_top.sv @@
// Run-length coded 4-bit alpha sprite rasterizer.
// Input channel: in_valid / in_stall with sprite_byte and first_of_frame; a byte
// transfers on a clock edge with in_valid high and in_stall low. first_of_frame
// returns the cursor to the origin and marks the byte as a control byte.
// Output channel: out_valid / out_stall with pixel_x, pixel_y, coverage, colour
// and last; last marks the final pixel produced by one input byte.
// Configuration: cfg_wen writes cfg_data into register cfg_index; write only
// while the block is idle.
// Path: a transferred byte is registered in the decode register and decoded
// from it; its pixels are loaded into the pixel register once that has room.
// Throughput: one pixel leaves per cycle while out_stall is low, through a
// two-entry pixel register; a data byte gives up to two pixels, a control byte
// or a fully clipped byte none. The next byte is taken while the last pixel of
// the previous one is still being offered.
// Reset: clears the cursor, the open run and all valid flags; registers return
// to their reset values. No clearing pass is needed.
// Stall: when out_stall is held the pending pixels hold, the decode register
// fills and in_stall rises; nothing is dropped.
module rle_alpha_sprite_rasterizer_top #(
	parameter int COORD_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [rasr_pkg::REG_INDEX_BITS-1:0] cfg_index,
	input  logic [rasr_pkg::REG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          sprite_byte,
	input  logic                                first_of_frame,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [COORD_BITS-1:0]               pixel_x,
	output logic [COORD_BITS-1:0]               pixel_y,
	output logic [3:0]                          coverage,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic                                last
);
	import rasr_pkg::*;

	rasr_cfg_t             cfg;
	logic                  queue_free, load;
	logic                  pix0_valid, pix1_valid;
	logic [COORD_BITS-1:0] pix0_x, pix0_y, pix1_x, pix1_y;
	rasr_pix_t             pix0, pix1;

	rasr_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	rasr_decode #(.COORD_BITS(COORD_BITS)) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sprite_byte(sprite_byte),
		.first_of_frame(first_of_frame),
		.queue_free(queue_free),
		.load(load),
		.pix0_valid(pix0_valid),
		.pix0_x(pix0_x),
		.pix0_y(pix0_y),
		.pix0(pix0),
		.pix1_valid(pix1_valid),
		.pix1_x(pix1_x),
		.pix1_y(pix1_y),
		.pix1(pix1)
	);

	rasr_out_queue #(.COORD_BITS(COORD_BITS)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.pix0_valid(pix0_valid),
		.pix0_x(pix0_x),
		.pix0_y(pix0_y),
		.pix0(pix0),
		.pix1_valid(pix1_valid),
		.pix1_x(pix1_x),
		.pix1_y(pix1_y),
		.pix1(pix1),
		.queue_free(queue_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.coverage(coverage),
		.red(red),
		.green(green),
		.blue(blue),
		.last(last)
	);

endmodule

@@ tb/rle_alpha_sprite_rasterizer_top_test.sv @@
module rle_alpha_sprite_rasterizer_top_test;
	import rasr_pkg::*;

	localparam int COORD_BITS = 12;
	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_BYTES = 1300;
	localparam int MAX_REPORTS = 40;
	localparam logic [12:0] CLIP_CAP = 13'(1 << COORD_BITS);

	localparam logic [1:0] KIND_PIXEL_SKIP0 = 2'b10;
	localparam logic [1:0] KIND_PIXEL_SKIP1 = 2'b11;

	typedef struct packed {
		logic [11:0] col;
		logic [11:0] row;
		logic [3:0] cov;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic last;
	} raster_pixel_t;

	typedef enum logic {ROW_REG, ROW_BYTE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [REG_INDEX_BITS-1:0] idx;
		logic [REG_DATA_BITS-1:0] data;
		logic [7:0] b;
		logic first;
		logic typed;
		logic [1:0] typed_n;
		raster_pixel_t e0;
		raster_pixel_t e1;
	} stim_row_t;

	typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_BEAT} flow_style_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [REG_INDEX_BITS-1:0] cfg_index;
	logic [REG_DATA_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] sprite_byte;
	logic first_of_frame;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [3:0] coverage;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic last;

	rasr_cfg_t regs;
	logic [5:0] run_left;
	logic [15:0] col_count;
	logic [16:0] cur_x;
	logic [16:0] cur_y;

	raster_pixel_t pixels_due[$];
	stim_row_t plan[$];

	int bytes_sent;
	int pixels_seen = 0;
	int mismatches = 0;
	int settings_used;
	int burst_left;
	int quiet_cycles = 0;
	int flow_cycle = 0;
	flow_style_t flow_style = FLOW_FREE;
	logic cfg_open;

	rle_alpha_sprite_rasterizer_top #(.COORD_BITS(COORD_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sprite_byte(sprite_byte),
		.first_of_frame(first_of_frame),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.coverage(coverage),
		.red(red),
		.green(green),
		.blue(blue),
		.last(last)
	);

	always #CLK_HALF clk = ~clk;

	function automatic logic [12:0] clip_extent(input logic [12:0] d);
		return (d > CLIP_CAP) ? CLIP_CAP : d;
	endfunction

	function automatic raster_pixel_t white_px(input logic [11:0] col, input logic [11:0] row,
			input logic [3:0] cov, input logic fin);
		return {col, row, cov, WHITE, WHITE, WHITE, fin};
	endfunction

	task automatic wrap_line();
		if (col_count >= {4'b0, regs.sprite_width}) begin
			col_count = col_count - {4'b0, regs.sprite_width};
			cur_y = cur_y + 17'd1;
			cur_x = cur_x - {5'b0, regs.sprite_width};
		end
	endtask

	task automatic plot_nibble(input logic [3:0] nib, output logic hit, output raster_pixel_t px);
		logic [7:0] idx;
		wrap_line();
		idx = {regs.palette_select, nib};
		hit = !cur_x[16] && !cur_y[16] && cur_x < {4'b0, clip_extent(regs.dest_width)} &&
			cur_y < {4'b0, clip_extent(regs.dest_height)};
		px.col = cur_x[11:0];
		px.row = cur_y[11:0];
		px.cov = nib;
		px.red = regs.palette_mode ? PAL_RED[idx] : WHITE;
		px.green = regs.palette_mode ? PAL_GREEN[idx] : WHITE;
		px.blue = regs.palette_mode ? PAL_BLUE[idx] : WHITE;
		px.last = 1'b0;
		cur_x = cur_x + 17'd1;
		col_count = col_count + 16'd1;
	endtask

	task automatic decode_sprite_byte(input logic [7:0] b, input logic f, output int n,
			output raster_pixel_t p0, output raster_pixel_t p1);
		logic closing;
		logic hit0, hit1;
		raster_pixel_t q0, q1;
		n = 0;
		p0 = '0;
		p1 = '0;
		if (f) begin
			cur_x = {{4{regs.origin_x[12]}}, regs.origin_x};
			cur_y = {{4{regs.origin_y[12]}}, regs.origin_y};
			col_count = '0;
			run_left = '0;
		end
		if (run_left == 6'd0) begin
			case (b[7:6])
				KIND_RUN: begin
					run_left = b[5:0];
				end
				KIND_LINE_SKIP: begin
					cur_y = cur_y + {11'b0, b[5:0]};
				end
				default: begin
					col_count = col_count + {10'b0, b[5:0]};
					cur_x = cur_x + {11'b0, b[5:0]};
					wrap_line();
				end
			endcase
		end else begin
			closing = (run_left == 6'd1);
			run_left = run_left - 6'd1;
			plot_nibble(b[3:0], hit0, q0);
			hit1 = 1'b0;
			if (!(closing && b[7:4] == 4'd0))
				plot_nibble(b[7:4], hit1, q1);
			if (hit0) begin
				p0 = q0;
				n = 1;
			end
			if (hit1) begin
				if (n == 0)
					p0 = q1;
				else
					p1 = q1;
				n++;
			end
			if (n == 1)
				p0.last = 1'b1;
			if (n == 2)
				p1.last = 1'b1;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic f, input logic typed,
			input logic [1:0] typed_n, input raster_pixel_t e0, input raster_pixel_t e1);
		int n;
		raster_pixel_t p0, p1;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		sprite_byte <= b;
		first_of_frame <= f;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		decode_sprite_byte(b, f, n, p0, p1);
		if (typed) begin
			n = typed_n;
			p0 = e0;
			p1 = e1;
		end
		if (n > 0)
			pixels_due.push_back(p0);
		if (n > 1)
			pixels_due.push_back(p1);
	endtask

	task automatic feed(input logic [7:0] b, input logic f);
		send_byte(b, f, 1'b0, 2'd0, '0, '0);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_INDEX_BITS-1:0] idx,
			input logic [REG_DATA_BITS-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_SPRITE_WIDTH: regs.sprite_width = data[11:0];
			REG_ORIGIN_X: regs.origin_x = data;
			REG_ORIGIN_Y: regs.origin_y = data;
			REG_DEST_WIDTH: regs.dest_width = data;
			REG_DEST_HEIGHT: regs.dest_height = data;
			REG_PALETTE_MODE: regs.palette_mode = data[0];
			REG_PALETTE_SELECT: regs.palette_select = data[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic add_reg(input logic [REG_INDEX_BITS-1:0] idx,
			input logic [REG_DATA_BITS-1:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = data;
		plan.push_back(r);
	endtask

	task automatic add_typed(input logic [7:0] b, input logic f, input logic typed,
			input logic [1:0] n, input raster_pixel_t e0, input raster_pixel_t e1);
		stim_row_t r;
		r = '0;
		r.kind = ROW_BYTE;
		r.b = b;
		r.first = f;
		r.typed = typed;
		r.typed_n = n;
		r.e0 = e0;
		r.e1 = e1;
		plan.push_back(r);
	endtask

	task automatic add_byte(input logic [7:0] b, input logic f);
		add_typed(b, f, 1'b0, 2'd0, '0, '0);
	endtask

	task automatic build_directed();
		// reset settings: width 1, origin 0, white
		add_typed({KIND_RUN, 6'd1}, 1'b1, 1'b1, 2'd0, '0, '0);
		add_typed(8'h5A, 1'b0, 1'b1, 2'd2, white_px(12'd0, 12'd0, 4'hA, 1'b0),
			white_px(12'd0, 12'd1, 4'h5, 1'b1));
		add_byte({KIND_RUN, 6'd2}, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h0F, 1'b0);
		add_typed({KIND_RUN, 6'd0}, 1'b0, 1'b1, 2'd0, '0, '0);
		add_typed({KIND_LINE_SKIP, 6'd1}, 1'b0, 1'b1, 2'd0, '0, '0);
		add_byte({KIND_PIXEL_SKIP0, 6'd1}, 1'b0);
		add_byte({KIND_PIXEL_SKIP1, 6'd63}, 1'b0);
		add_byte({KIND_RUN, 6'd1}, 1'b0);
		add_byte(8'hF0, 1'b0);
		// far corner, palette row 15, capped destination
		add_reg(REG_PALETTE_MODE, 13'd1);
		add_reg(REG_PALETTE_SELECT, 13'd15);
		add_reg(REG_SPRITE_WIDTH, 13'd4095);
		add_reg(REG_ORIGIN_X, 13'd4090);
		add_reg(REG_ORIGIN_Y, 13'd4095);
		add_reg(REG_DEST_WIDTH, 13'd8191);
		add_reg(REG_DEST_HEIGHT, 13'd4096);
		add_byte({KIND_RUN, 6'd5}, 1'b1);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h12, 1'b0);
		add_byte({KIND_RUN, 6'd1}, 1'b1);
		add_byte(8'h80, 1'b0);
		// zero sprite width, origin above the top edge
		add_reg(REG_SPRITE_WIDTH, 13'd0);
		add_reg(REG_ORIGIN_X, 13'd0);
		add_reg(REG_ORIGIN_Y, 13'h1FFF);
		add_reg(REG_PALETTE_MODE, 13'd0);
		add_reg(REG_PALETTE_SELECT, 13'd0);
		add_byte({KIND_RUN, 6'd2}, 1'b1);
		add_byte(8'h21, 1'b0);
		add_byte(8'h43, 1'b0);
		// empty destination
		add_reg(REG_ORIGIN_X, 13'h1000);
		add_reg(REG_DEST_WIDTH, 13'd0);
		add_typed({KIND_RUN, 6'd1}, 1'b1, 1'b1, 2'd0, '0, '0);
		add_typed(8'hFF, 1'b0, 1'b1, 2'd0, '0, '0);
	endtask

	function automatic logic [12:0] pick_sprite_width();
		case ($urandom_range(0, 11))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd4095;
			3: return 13'($urandom);
			default: return 13'($urandom_range(2, 40));
		endcase
	endfunction

	function automatic logic [12:0] pick_origin();
		case ($urandom_range(0, 11))
			0: return 13'h1000;
			1: return 13'h0FFF;
			2: return 13'($urandom);
			default: return 13'($urandom_range(0, 64) - 8);
		endcase
	endfunction

	function automatic logic [12:0] pick_extent();
		case ($urandom_range(0, 13))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd4096;
			3: return 13'd8191;
			4: return 13'($urandom);
			default: return 13'($urandom_range(8, 80));
		endcase
	endfunction

	function automatic logic [5:0] skip_len();
		return ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
	endfunction

	task automatic random_setup();
		wait_idle();
		write_reg(REG_SPRITE_WIDTH, pick_sprite_width());
		write_reg(REG_ORIGIN_X, pick_origin());
		write_reg(REG_ORIGIN_Y, pick_origin());
		write_reg(REG_DEST_WIDTH, pick_extent());
		write_reg(REG_DEST_HEIGHT, pick_extent());
		write_reg(REG_PALETTE_MODE, 13'($urandom));
		write_reg(REG_PALETTE_SELECT, 13'($urandom));
		cfg_wen <= 1'b0;
		settings_used++;
	endtask

	task automatic random_frame(input int limit);
		int pick;
		int len;
		logic [7:0] b;
		feed({2'($urandom), skip_len()}, 1'b1);
		while (bytes_sent < limit) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 6);
				feed({KIND_RUN, 6'(len)}, 1'b0);
				for (int k = 0; k < len; k++) begin
					b = 8'($urandom);
					if (k == len - 1 && $urandom_range(0, 1) == 0)
						b[7:4] = 4'd0;
					feed(b, 1'b0);
				end
			end else if (pick < 68) begin
				feed({KIND_LINE_SKIP, skip_len()}, 1'b0);
			end else if (pick < 82) begin
				feed({1'b1, 1'($urandom), skip_len()}, 1'b0);
			end else if (pick < 87) begin
				feed({KIND_RUN, 6'd0}, 1'b0);
			end else if (pick < 94) begin
				feed({2'($urandom), skip_len()}, 1'b1);
			end else begin
				feed(8'($urandom), 1'($urandom));
			end
		end
	endtask

	// zero width wraps on every pixel; negative origins carry both cursors round through zero
	task automatic counter_wrap_run();
		wait_idle();
		write_reg(REG_SPRITE_WIDTH, 13'd0);
		write_reg(REG_ORIGIN_X, 13'h1000);
		write_reg(REG_ORIGIN_Y, 13'h1000);
		write_reg(REG_DEST_WIDTH, 13'd4096);
		write_reg(REG_DEST_HEIGHT, 13'd8191);
		write_reg(REG_PALETTE_MODE, 13'd0);
		cfg_wen <= 1'b0;
		feed({KIND_RUN, 6'd0}, 1'b1);
		repeat (66) feed({KIND_PIXEL_SKIP1, 6'd63}, 1'b0);
		feed({KIND_RUN, 6'd1}, 1'b0);
		feed(8'h21, 1'b0);
		repeat (64) feed({KIND_LINE_SKIP, 6'd63}, 1'b0);
		feed({KIND_RUN, 6'd2}, 1'b0);
		feed(8'h87, 1'b0);
		feed(8'h09, 1'b0);
		wait_idle();
		write_reg(REG_SPRITE_WIDTH, 13'd20);
		cfg_wen <= 1'b0;
		feed({KIND_RUN, 6'd2}, 1'b0);
		feed(8'hA9, 1'b0);
		feed(8'hCB, 1'b0);
		settings_used += 2;
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		raster_pixel_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			pixels_seen++;
			got = {pixel_x, pixel_y, coverage, red, green, blue, last};
			if (pixels_due.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: pixel at (%0d,%0d) with none expected", $time, pixel_x,
						pixel_y);
				mismatches++;
			end else begin
				want = pixels_due.pop_front();
				check_field("pixel_x", want.col, got.col);
				check_field("pixel_y", want.row, got.row);
				check_field("coverage", want.cov, got.cov);
				check_field("red", want.red, got.red);
				check_field("green", want.green, got.green);
				check_field("blue", want.blue, got.blue);
				check_field("last", want.last, got.last);
			end
		end
		flow_cycle++;
		if (flow_cycle % 80 == 0)
			flow_style = flow_style_t'($urandom_range(0, 3));
		case (flow_style)
			FLOW_FREE: out_stall <= 1'b0;
			FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			FLOW_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
			default: out_stall <= (flow_cycle % 3 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d pixels still due", $time,
					quiet_cycles, pixels_due.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t row;
		int directed_done;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_SPRITE_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		sprite_byte = 8'd0;
		first_of_frame = 1'b0;
		bytes_sent = 0;
		settings_used = 1;
		burst_left = 0;
		cfg_open = 1'b0;
		regs.sprite_width = 12'd1;
		regs.origin_x = '0;
		regs.origin_y = '0;
		regs.dest_width = 13'd4096;
		regs.dest_height = 13'd4096;
		regs.palette_mode = 1'b0;
		regs.palette_select = 4'd0;
		run_left = '0;
		col_count = '0;
		cur_x = '0;
		cur_y = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_directed();
		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_REG) begin
				if (!cfg_open) begin
					wait_idle();
					settings_used++;
				end
				write_reg(row.idx, row.data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_wen <= 1'b0;
					cfg_open = 1'b0;
				end
				send_byte(row.b, row.first, row.typed, row.typed_n, row.e0, row.e1);
			end
		end

		counter_wrap_run();

		directed_done = bytes_sent;
		while (bytes_sent < directed_done + RANDOM_BYTES) begin
			random_setup();
			random_frame(bytes_sent + $urandom_range(40, 160));
		end

		wait_idle();
		$display("Sent %0d sprite bytes and checked %0d pixels over %0d register settings,",
			bytes_sent, pixels_seen, settings_used);
		$display("covering runs, line and pixel skips, column wraps, clipping and counter wrap.");
		if (mismatches == 0 && pixels_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d pixels never seen", mismatches, pixels_due.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
